>>> src/tot_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the tilt orientation tracker
package tot_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DEV,
    S_VIB,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef logic [2:0] ori_t;

  localparam ori_t ORI_UNKNOWN = 3'd0;
  localparam ori_t ORI_FLAT    = 3'd1;
  localparam ori_t ORI_DEG0    = 3'd2;
  localparam ori_t ORI_DEG90   = 3'd3;
  localparam ori_t ORI_DEG180  = 3'd4;
  localparam ori_t ORI_DEG270  = 3'd5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] REG_BIAS_ALPHA     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_NORMAL   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_VIB      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VIB_THRESHOLD  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DOM_THRESHOLD  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FLAT_THRESHOLD = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DEC_INTERVAL   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CONF_NEEDED    = 3'd7;

  // filter slots: gyro bias x/y/z then accel x/y
  localparam int NumFilt = 5;
  localparam logic [2:0] SLOT_GYRO_Z  = 3'd2;
  localparam logic [2:0] SLOT_ACCEL_X = 3'd3;
  localparam logic [2:0] SLOT_ACCEL_Y = 3'd4;

  // q8 gains above unity clamp to unity
  function automatic logic [8:0] sat_gain(input logic [8:0] a);
    sat_gain = a[8] ? 9'd256 : a;
  endfunction

endpackage

>>> src/tilt_orientation_tracker_core.sv
`timescale 1ns / 1ps
// top level of the tilt orientation tracker
//
// One transaction in gives one transaction out. A sample is taken only while
// in_ready is high. The core then walks the three gyro bias filters and the two
// accel filters through one shared multiply-round-shift unit (multiply, then
// add; the gyro slots also add to the deviation sum). The vibration check and
// the orientation decision each have a state of their own. The next sample can
// be taken once the result has moved to the output register and the core is
// back in idle. The first sample after reset only seeds the filters and goes
// straight to the output step. A finished result waits in the output register
// while the next sample is accepted. If a result is still waiting there when
// the next one finishes, the core holds until it is taken.
module tilt_orientation_tracker_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              accel_x,
  input  logic signed [15:0]              accel_y,
  input  logic signed [15:0]              gyro_x,
  input  logic signed [15:0]              gyro_y,
  input  logic signed [15:0]              gyro_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      orientation,
  output logic                            vibrating,
  output logic                            decision_made,
  output logic signed [15:0]              gravity_x,
  output logic signed [15:0]              gravity_y,
  input  logic                            cfg_we,
  input  logic [tot_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tot_pkg::CfgDataW-1:0]    cfg_wdata
);

  // configuration
  logic [8:0]  bias_alpha;
  logic [8:0]  alpha_normal;
  logic [8:0]  alpha_vibrating;
  logic [17:0] energy_limit;
  logic [14:0] dom_threshold;
  logic [14:0] flat_threshold;
  logic [7:0]  decision_interval;
  logic [7:0]  confidence_needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_alpha        <= 9'd4;
      alpha_normal      <= 9'd32;
      alpha_vibrating   <= 9'd8;
      energy_limit      <= 18'd15000;
      dom_threshold     <= 15'd4096;
      flat_threshold    <= 15'd2458;
      decision_interval <= 8'd20;
      confidence_needed <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        tot_pkg::REG_BIAS_ALPHA:     bias_alpha        <= cfg_wdata[8:0];
        tot_pkg::REG_ALPHA_NORMAL:   alpha_normal      <= cfg_wdata[8:0];
        tot_pkg::REG_ALPHA_VIB:      alpha_vibrating   <= cfg_wdata[8:0];
        tot_pkg::REG_VIB_THRESHOLD:  energy_limit      <= cfg_wdata[17:0];
        tot_pkg::REG_DOM_THRESHOLD:  dom_threshold     <= cfg_wdata[14:0];
        tot_pkg::REG_FLAT_THRESHOLD: flat_threshold    <= cfg_wdata[14:0];
        tot_pkg::REG_DEC_INTERVAL:   decision_interval <= cfg_wdata[7:0];
        tot_pkg::REG_CONF_NEEDED:    confidence_needed <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  tot_pkg::state_t state, state_next;
  logic [2:0]      idx;
  logic            seeded;
  logic            out_load;
  logic            in_take;

  always_comb begin
    state_next = state;
    case (state)
      tot_pkg::S_IDLE:   if (in_valid) state_next = seeded ? tot_pkg::S_MUL : tot_pkg::S_DONE;
      tot_pkg::S_MUL:    state_next = tot_pkg::S_ADD;
      tot_pkg::S_ADD: begin
        if (idx < tot_pkg::SLOT_ACCEL_X)       state_next = tot_pkg::S_DEV;
        else if (idx == tot_pkg::SLOT_ACCEL_Y) state_next = tot_pkg::S_DECIDE;
        else                                   state_next = tot_pkg::S_MUL;
      end
      tot_pkg::S_DEV:    state_next = (idx == tot_pkg::SLOT_GYRO_Z) ? tot_pkg::S_VIB
                                                                    : tot_pkg::S_MUL;
      tot_pkg::S_VIB:    state_next = tot_pkg::S_MUL;
      tot_pkg::S_DECIDE: state_next = tot_pkg::S_DONE;
      tot_pkg::S_DONE:   if (!out_valid || out_ready) state_next = tot_pkg::S_IDLE;
      default:           state_next = tot_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == tot_pkg::S_IDLE);
    in_take  = in_valid && (state == tot_pkg::S_IDLE);
    out_load = (state == tot_pkg::S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tot_pkg::S_IDLE;
    else     state <= state_next;
  end

  // sample and filter slots: gyro x/y/z, accel x/y
  logic signed [15:0] smp  [tot_pkg::NumFilt];
  logic signed [15:0] filt [tot_pkg::NumFilt];

  // shared multiply-round-shift unit
  logic [8:0]         gain;
  logic signed [9:0]  gain_s;
  logic signed [16:0] diff;
  logic signed [26:0] mul_res;
  logic signed [26:0] prod;
  logic signed [26:0] rnd;
  logic signed [18:0] step;
  logic signed [18:0] fsum;
  logic signed [15:0] fnew;
  logic               vib;

  always_comb begin
    gain    = tot_pkg::sat_gain((idx < tot_pkg::SLOT_ACCEL_X) ? bias_alpha :
                                (vib ? alpha_vibrating : alpha_normal));
    gain_s  = signed'({1'b0, gain});
    diff    = 17'(smp[idx]) - 17'(filt[idx]);
    mul_res = diff * gain_s;
    rnd     = prod + 27'sd128;
    step    = rnd[26:8];
    fsum    = 19'(filt[idx]) + step;
    fnew    = fsum[15:0];
  end

  // deviation of the gyro sample from its updated bias
  logic signed [16:0] dev;
  logic [16:0]        dev_abs;
  logic [17:0]        energy;

  always_comb begin
    dev     = 17'(smp[idx]) - 17'(filt[idx]);
    dev_abs = dev[16] ? 17'(-dev) : 17'(dev);
  end

  // orientation decision
  logic [7:0]         decim_count;
  logic [7:0]         repeat_count;
  tot_pkg::ori_t      pending;
  tot_pkg::ori_t      current;
  logic               made;
  logic [7:0]         decim_inc;
  logic [7:0]         interval_eff;
  logic               decide_now;
  logic signed [15:0] fx, fy;
  logic [15:0]        ax, ay;
  logic signed [16:0] dom_s;
  logic               cand_ok;
  tot_pkg::ori_t      cand;
  logic [7:0]         repeat_inc;

  always_comb begin
    decim_inc    = decim_count + 8'd1;
    interval_eff = (decision_interval == 8'd0) ? 8'd1 : decision_interval;
    decide_now   = (decim_inc >= interval_eff);
    fx           = filt[tot_pkg::SLOT_ACCEL_X];
    fy           = filt[tot_pkg::SLOT_ACCEL_Y];
    ax           = fx[15] ? 16'(-17'(fx)) : 16'(fx);
    ay           = fy[15] ? 16'(-17'(fy)) : 16'(fy);
    dom_s        = signed'({2'b00, dom_threshold});
    cand_ok      = 1'b0;
    cand         = tot_pkg::ORI_UNKNOWN;
    if (ax < 16'(flat_threshold) && ay < 16'(flat_threshold)) begin
      cand_ok = 1'b1;
      cand    = tot_pkg::ORI_FLAT;
    end else if (ax > ay) begin
      if (17'(fx) < -dom_s) begin
        cand_ok = 1'b1;
        cand    = tot_pkg::ORI_DEG90;
      end else if (17'(fx) > dom_s) begin
        cand_ok = 1'b1;
        cand    = tot_pkg::ORI_DEG270;
      end
    end else begin
      if (17'(fy) < -dom_s) begin
        cand_ok = 1'b1;
        cand    = tot_pkg::ORI_DEG0;
      end else if (17'(fy) > dom_s) begin
        cand_ok = 1'b1;
        cand    = tot_pkg::ORI_DEG180;
      end
    end
    repeat_inc = (repeat_count == 8'd255) ? repeat_count : repeat_count + 8'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      idx          <= 3'd0;
      decim_count  <= 8'd0;
      repeat_count <= 8'd0;
      pending      <= tot_pkg::ORI_UNKNOWN;
      current      <= tot_pkg::ORI_UNKNOWN;
      vib          <= 1'b0;
      made         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_take) begin
        seeded <= 1'b1;
        idx    <= 3'd0;
        vib    <= 1'b0;
        made   <= 1'b0;
      end
      // accel y is the last slot, the index stays there until the next sample
      if (state == tot_pkg::S_ADD && idx == tot_pkg::SLOT_ACCEL_X) idx <= idx + 3'd1;
      if (state == tot_pkg::S_DEV) idx <= idx + 3'd1;
      if (state == tot_pkg::S_VIB) vib <= (energy > energy_limit);
      if (state == tot_pkg::S_DECIDE) begin
        if (decide_now) begin
          decim_count <= 8'd0;
          made        <= 1'b1;
          if (cand_ok) begin
            if (cand == pending) begin
              repeat_count <= repeat_inc;
              if (repeat_inc >= confidence_needed) current <= cand;
            end else begin
              pending      <= cand;
              repeat_count <= 8'd0;
            end
          end
        end else begin
          decim_count <= decim_inc;
        end
      end
      if (out_load)                  out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp[0] <= gyro_x;
      smp[1] <= gyro_y;
      smp[2] <= gyro_z;
      smp[3] <= accel_x;
      smp[4] <= accel_y;
      energy <= 18'd0;
      // first sample seeds every filter
      if (!seeded) begin
        filt[0] <= gyro_x;
        filt[1] <= gyro_y;
        filt[2] <= gyro_z;
        filt[3] <= accel_x;
        filt[4] <= accel_y;
      end
    end
    if (state == tot_pkg::S_MUL) prod <= mul_res;
    if (state == tot_pkg::S_ADD) filt[idx] <= fnew;
    if (state == tot_pkg::S_DEV) energy <= energy + 18'(dev_abs);
    if (out_load) begin
      orientation   <= current;
      vibrating     <= vib;
      decision_made <= made;
      gravity_x     <= filt[tot_pkg::SLOT_ACCEL_X];
      gravity_y     <= filt[tot_pkg::SLOT_ACCEL_Y];
    end
  end

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= tot_pkg::SLOT_ACCEL_Y)
    else $error("filter slot index out of range");

  a_seeded_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag dropped");

  a_seed_path: assert property (@(posedge clk) disable iff (rst)
    (in_take && !seeded) |=> (state == tot_pkg::S_DONE))
    else $error("seeding sample did not go straight to output");

  a_decide_clears: assert property (@(posedge clk) disable iff (rst)
    (state == tot_pkg::S_DECIDE && decide_now) |=> (decim_count == 8'd0 && made))
    else $error("decision did not restart the interval count");

  a_ori_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (orientation <= tot_pkg::ORI_DEG270))
    else $error("orientation code out of range");

endmodule

>>> dv/tilt_tracker_check.sv
`timescale 1ns / 1ps
// predicts each orientation result of the tilt tracker and compares it with the core
module tilt_tracker_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [15:0]           accel_x,
  input  logic signed [15:0]           accel_y,
  input  logic signed [15:0]           gyro_x,
  input  logic signed [15:0]           gyro_y,
  input  logic signed [15:0]           gyro_z,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [2:0]                   orientation,
  input  logic                         vibrating,
  input  logic                         decision_made,
  input  logic signed [15:0]           gravity_x,
  input  logic signed [15:0]           gravity_y,
  input  logic                         cfg_we,
  input  logic [tot_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tot_pkg::CfgDataW-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           outstanding,
  output int                           readings_checked,
  output int                           decisions_seen,
  output int                           vibrating_seen
);

  typedef struct packed {
    tot_pkg::ori_t      orientation;
    logic               vibrating;
    logic               decision_made;
    logic signed [15:0] grav_x;
    logic signed [15:0] grav_y;
  } reading_t;

  reading_t expected_readings [$];
  reading_t want;

  // register copy
  logic [8:0]  r_bias_alpha, r_alpha_norm, r_alpha_vib;
  logic [17:0] r_vib_thr;
  logic [14:0] r_dom_thr, r_flat_thr;
  logic [7:0]  r_interval, r_confidence;

  // tracker state
  logic               seeded;
  logic signed [15:0] bias [3];
  logic signed [15:0] grav [2];
  logic signed [15:0] gin [3];
  logic [7:0]         decim, repeats;
  tot_pkg::ori_t      pending_ori, held_ori, cand;
  logic               have_cand;
  int                 energy, dev, fx, fy, ax, ay, dom, flat;

  // rounded q8 low-pass step with floor shift
  function automatic logic signed [15:0] q8_filter(input logic signed [15:0] f,
                                                   input logic signed [15:0] x,
                                                   input logic [8:0] a);
    int g, prod, sum;
    g = (a > 9'd256) ? 256 : int'(a);
    prod = (int'(x) - int'(f)) * g + 128;
    sum = int'(f) + (prod >>> 8);
    return sum[15:0];
  endfunction

  task automatic note_mismatch(input string what, input int got, input int wanted);
    $display("mismatch at result %0d, %s: got %0d, expected %0d",
             readings_checked, what, got, wanted);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      r_bias_alpha = 9'd4;
      r_alpha_norm = 9'd32;
      r_alpha_vib = 9'd8;
      r_vib_thr = 18'd15000;
      r_dom_thr = 15'd4096;
      r_flat_thr = 15'd2458;
      r_interval = 8'd20;
      r_confidence = 8'd2;
      seeded = 1'b0;
      for (int k = 0; k < 3; k++) bias[k] = '0;
      grav[0] = '0;
      grav[1] = '0;
      decim = '0;
      repeats = '0;
      pending_ori = tot_pkg::ORI_UNKNOWN;
      held_ori = tot_pkg::ORI_UNKNOWN;
      expected_readings.delete();
      mismatches = 0;
      readings_checked = 0;
      decisions_seen = 0;
      vibrating_seen = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          note_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = expected_readings.pop_front();
          if (orientation !== want.orientation)
            note_mismatch("orientation", int'(orientation), int'(want.orientation));
          if (vibrating !== want.vibrating)
            note_mismatch("vibrating", int'(vibrating), int'(want.vibrating));
          if (decision_made !== want.decision_made)
            note_mismatch("decision_made", int'(decision_made), int'(want.decision_made));
          if (gravity_x !== want.grav_x)
            note_mismatch("gravity_x", int'(gravity_x), int'(want.grav_x));
          if (gravity_y !== want.grav_y)
            note_mismatch("gravity_y", int'(gravity_y), int'(want.grav_y));
        end
        readings_checked = readings_checked + 1;
      end

      if (cfg_we) begin
        case (cfg_index)
          tot_pkg::REG_BIAS_ALPHA:     r_bias_alpha = cfg_wdata[8:0];
          tot_pkg::REG_ALPHA_NORMAL:   r_alpha_norm = cfg_wdata[8:0];
          tot_pkg::REG_ALPHA_VIB:      r_alpha_vib = cfg_wdata[8:0];
          tot_pkg::REG_VIB_THRESHOLD:  r_vib_thr = cfg_wdata[17:0];
          tot_pkg::REG_DOM_THRESHOLD:  r_dom_thr = cfg_wdata[14:0];
          tot_pkg::REG_FLAT_THRESHOLD: r_flat_thr = cfg_wdata[14:0];
          tot_pkg::REG_DEC_INTERVAL:   r_interval = cfg_wdata[7:0];
          tot_pkg::REG_CONF_NEEDED:    r_confidence = cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        gin[0] = gyro_x;
        gin[1] = gyro_y;
        gin[2] = gyro_z;
        want.vibrating = 1'b0;
        want.decision_made = 1'b0;
        if (!seeded) begin
          // first sample only seeds the filters
          for (int k = 0; k < 3; k++) bias[k] = gin[k];
          grav[0] = accel_x;
          grav[1] = accel_y;
          seeded = 1'b1;
        end else begin
          energy = 0;
          for (int k = 0; k < 3; k++) begin
            bias[k] = q8_filter(bias[k], gin[k], r_bias_alpha);
            dev = int'(gin[k]) - int'(bias[k]);
            energy = energy + ((dev < 0) ? -dev : dev);
          end
          want.vibrating = (energy > int'(r_vib_thr));
          grav[0] = q8_filter(grav[0], accel_x, want.vibrating ? r_alpha_vib : r_alpha_norm);
          grav[1] = q8_filter(grav[1], accel_y, want.vibrating ? r_alpha_vib : r_alpha_norm);
          if (want.vibrating) vibrating_seen = vibrating_seen + 1;
          decim = decim + 8'd1;
          if (decim >= r_interval) begin
            decim = '0;
            want.decision_made = 1'b1;
            decisions_seen = decisions_seen + 1;
            fx = int'(grav[0]);
            fy = int'(grav[1]);
            ax = (fx < 0) ? -fx : fx;
            ay = (fy < 0) ? -fy : fy;
            dom = int'(r_dom_thr);
            flat = int'(r_flat_thr);
            have_cand = 1'b1;
            cand = tot_pkg::ORI_UNKNOWN;
            if (ax < flat && ay < flat) begin
              cand = tot_pkg::ORI_FLAT;
            end else if (ax > ay) begin
              if (fx < -dom) cand = tot_pkg::ORI_DEG90;
              else if (fx > dom) cand = tot_pkg::ORI_DEG270;
              else have_cand = 1'b0;
            end else begin
              // equal magnitudes fall to the y axis
              if (fy < -dom) cand = tot_pkg::ORI_DEG0;
              else if (fy > dom) cand = tot_pkg::ORI_DEG180;
              else have_cand = 1'b0;
            end
            if (have_cand) begin
              if (cand == pending_ori) begin
                if (repeats != 8'd255) repeats = repeats + 8'd1;
                if (repeats >= r_confidence) held_ori = cand;
              end else begin
                // a new candidate is never adopted on its first sighting
                pending_ori = cand;
                repeats = '0;
              end
            end
          end
        end
        want.orientation = held_ori;
        want.grav_x = grav[0];
        want.grav_y = grav[1];
        expected_readings.push_back(want);
      end
      outstanding <= expected_readings.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// stimulus, stall watchdog and verdict for the tilt orientation tracker regression
module testbench;

  typedef enum int {
    POSE_FLAT,
    POSE_DEG0,
    POSE_DEG90,
    POSE_DEG180,
    POSE_DEG270,
    POSE_DIAG,
    POSE_RAIL
  } pose_t;

  localparam int STALL_LIMIT = 3000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [15:0]           accel_x = '0;
  logic signed [15:0]           accel_y = '0;
  logic signed [15:0]           gyro_x = '0;
  logic signed [15:0]           gyro_y = '0;
  logic signed [15:0]           gyro_z = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [2:0]                   orientation;
  logic                         vibrating;
  logic                         decision_made;
  logic signed [15:0]           gravity_x;
  logic signed [15:0]           gravity_y;
  logic                         cfg_we = 1'b0;
  logic [tot_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tot_pkg::CfgDataW-1:0] cfg_wdata = '0;

  int mismatches, outstanding, readings_checked, decisions_seen, vibrating_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings_loaded = 0;
  int samples_sent = 0;
  int stall_cycles = 0;
  int gyro_base [3];

  logic [tot_pkg::CfgIdxW-1:0]  staged_idx [$];
  logic [tot_pkg::CfgDataW-1:0] staged_val [$];

  tilt_orientation_tracker_core uut (.*);
  tilt_tracker_check tilt_check (.*);

  always #1 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("tilt_orientation_tracker_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int jitter(input int spread);
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic logic signed [15:0] rail_value();
    case ($urandom_range(2))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'h0000;
    endcase
  endfunction

  // mostly calm around the bias, sometimes a full-scale shake
  function automatic logic signed [15:0] gyro_reading(input int axis);
    logic [31:0] r;
    r = $urandom();
    if (r[6:0] < 7'd19) return r[31:16];
    return sat16(gyro_base[axis] + jitter(150));
  endfunction

  function automatic void shift_gyro_bases();
    for (int k = 0; k < 3; k++) gyro_base[k] = jitter(2000);
  endfunction

  function automatic void stage_reg(input logic [tot_pkg::CfgIdxW-1:0] idx,
                                    input logic [tot_pkg::CfgDataW-1:0] val);
    staged_idx.push_back(idx);
    staged_val.push_back(val);
  endfunction

  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] gx, input logic signed [15:0] gy,
                             input logic signed [15:0] gz);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    gyro_x <= gx;
    gyro_y <= gy;
    gyro_z <= gz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // outstanding is written with a nonblocking assignment, so let the clock advance before looking
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_staged_regs();
    wait_drained();
    while (staged_idx.size() != 0) begin
      cfg_we <= 1'b1;
      cfg_index <= staged_idx.pop_front();
      cfg_wdata <= staged_val.pop_front();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic hold_pose(input pose_t pose, input int len, input int spread);
    int cx, cy, m;
    m = $urandom_range(20000, 6000);
    cx = 0;
    cy = 0;
    case (pose)
      POSE_DEG0:   cy = -m;
      POSE_DEG90:  cx = -m;
      POSE_DEG180: cy = m;
      POSE_DEG270: cx = m;
      POSE_DIAG: begin
        cx = $urandom_range(1) ? m : -m;
        cy = $urandom_range(1) ? m : -m;
      end
      POSE_RAIL: begin
        cx = int'(rail_value());
        cy = int'(rail_value());
      end
      default: ;
    endcase
    repeat (len)
      send_sample(sat16(cx + jitter(spread)), sat16(cy + jitter(spread)),
                  gyro_reading(0), gyro_reading(1), gyro_reading(2));
  endtask

  // held poses with random content, broken up by raw noise samples
  task automatic run_poses(input int count);
    int left, len, spread;
    logic [31:0] r0, r1, r2;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        r0 = $urandom();
        r1 = $urandom();
        r2 = $urandom();
        send_sample(r0[15:0], r0[31:16], r1[15:0], r1[31:16], r2[15:0]);
        left--;
      end else begin
        len = $urandom_range(24, 3);
        if (len > left) len = left;
        spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(3000);
        hold_pose(pose_t'($urandom_range(6)), len, spread);
        left -= len;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 48;

    // unity gains so each sample lands straight in the filters
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'd300);
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'd256);
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'd511);
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'd262143);
    stage_reg(tot_pkg::REG_DOM_THRESHOLD, 18'd4096);
    stage_reg(tot_pkg::REG_FLAT_THRESHOLD, 18'd2458);
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd0);
    stage_reg(tot_pkg::REG_CONF_NEEDED, 18'd0);
    load_staged_regs();
    send_sample(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd5000, -16'sd5000, 16'sd0, 16'sd0, 16'sd0);
    send_sample(-16'sd5000, 16'sd5000, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd3000, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);

    // zero vibration threshold, frozen calm filter
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'd1);
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'd0);
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'd128);
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'd0);
    load_staged_regs();
    send_sample(16'sd1000, 16'sd2000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(-16'sd9000, 16'sd300, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

    // interval lowered below the running count
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd255);
    load_staged_regs();
    repeat (4) send_sample(-16'sd12000, 16'sd50, 16'sd1, 16'sd2, 16'sd3);
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd2);
    load_staged_regs();
    repeat (2) send_sample(-16'sd12000, 16'sd50, 16'sd1, 16'sd2, 16'sd3);

    // frozen bias, zero dominance and flat thresholds
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'd0);
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'd64);
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'd16);
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'd20000);
    stage_reg(tot_pkg::REG_DOM_THRESHOLD, 18'd0);
    stage_reg(tot_pkg::REG_FLAT_THRESHOLD, 18'd0);
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd3);
    stage_reg(tot_pkg::REG_CONF_NEEDED, 18'd1);
    load_staged_regs();
    shift_gyro_bases();
    run_poses(30);

    send_idle_pct = 48;
    recv_idle_pct = 28;
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'd4);
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'd128);
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'd8);
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'd15000);
    stage_reg(tot_pkg::REG_DOM_THRESHOLD, 18'd4096);
    stage_reg(tot_pkg::REG_FLAT_THRESHOLD, 18'd2458);
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd4);
    stage_reg(tot_pkg::REG_CONF_NEEDED, 18'd2);
    load_staged_regs();
    shift_gyro_bases();
    run_poses(20);
    wait_drained();
    run_poses(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'($urandom_range(511)));
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'($urandom_range(511)));
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'($urandom_range(511)));
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'($urandom_range(262143)));
    stage_reg(tot_pkg::REG_DOM_THRESHOLD, 18'($urandom_range(32767)));
    stage_reg(tot_pkg::REG_FLAT_THRESHOLD, 18'($urandom_range(6000)));
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'($urandom_range(6)));
    stage_reg(tot_pkg::REG_CONF_NEEDED, 18'($urandom_range(3)));
    load_staged_regs();
    shift_gyro_bases();
    run_poses(30);

    // long flat hold: the repeat count has to climb to its ceiling and stay there
    stage_reg(tot_pkg::REG_BIAS_ALPHA, 18'd256);
    stage_reg(tot_pkg::REG_ALPHA_NORMAL, 18'd256);
    stage_reg(tot_pkg::REG_ALPHA_VIB, 18'd200);
    stage_reg(tot_pkg::REG_VIB_THRESHOLD, 18'd262143);
    stage_reg(tot_pkg::REG_DOM_THRESHOLD, 18'd32767);
    stage_reg(tot_pkg::REG_FLAT_THRESHOLD, 18'd32767);
    stage_reg(tot_pkg::REG_DEC_INTERVAL, 18'd1);
    stage_reg(tot_pkg::REG_CONF_NEEDED, 18'd255);
    load_staged_regs();
    hold_pose(POSE_FLAT, 280, 1500);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d samples under %0d register settings", samples_sent, settings_loaded);
    $display("%0d results checked, %0d orientation decisions, %0d vibrating samples",
             readings_checked, decisions_seen, vibrating_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tilt_orientation_tracker_core regression: pass");
    end else begin
      $display("tilt_orientation_tracker_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tot_pkg.sv
src/tilt_orientation_tracker_core.sv
dv/tilt_tracker_check.sv
dv/testbench.sv
